// ===== hdl/olo_pkg.sv =====
`default_nettype none

package olo_pkg;

    localparam int unsigned TimeW     = 32;
    localparam int unsigned DebounceW = 10;
    localparam int unsigned DelayW    = 27;
    localparam int unsigned CfgDataW  = 27;
    localparam int unsigned CfgIdxW   = 2;

    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_ABSENCE  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_FULL_OFF = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_START_EN = 2'd3;

    localparam logic [DebounceW-1:0] DEBOUNCE_RST = 10'd50;
    localparam logic [DelayW-1:0]    ABSENCE_RST  = 27'd300000;
    localparam logic [DelayW-1:0]    FULL_OFF_RST = 27'd600000;
    localparam logic                 START_EN_RST = 1'b1;

    typedef enum logic [1:0] {
        DISP_NONE  = 2'd0,
        DISP_SLEEP = 2'd1,
        DISP_WAKE  = 2'd2
    } disp_cmd_t;

    typedef struct packed {
        logic [DebounceW-1:0] debounce_ms;
        logic [DelayW-1:0]    absence_timeout_ms;
        logic [DelayW-1:0]    power_down_ms;
    } cfg_t;

    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic             button_level;
        logic             motion_level;
        logic             listening;
        logic             light_now;
        logic             fan_now;
    } poll_t;

    typedef struct packed {
        logic      loads_write;
        logic      light_out;
        logic      fan_out;
        disp_cmd_t display_cmd;
        logic      engine_paused;
        logic      presence_enabled;
        logic      motion_seen;
        logic      temp_off;
        logic      full_off;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/olo_cfg.sv =====
`default_nettype none

module olo_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [olo_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [olo_pkg::CfgDataW-1:0]  cfg_data,
    output olo_pkg::cfg_t                      cfg
);

    olo_pkg::cfg_t cfg_reg;
    olo_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                olo_pkg::REG_DEBOUNCE: begin
                    cfg_next.debounce_ms = cfg_data[olo_pkg::DebounceW-1:0];
                end
                olo_pkg::REG_ABSENCE: begin
                    cfg_next.absence_timeout_ms = cfg_data[olo_pkg::DelayW-1:0];
                end
                olo_pkg::REG_FULL_OFF: begin
                    cfg_next.power_down_ms = cfg_data[olo_pkg::DelayW-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms        <= olo_pkg::DEBOUNCE_RST;
            cfg_reg.absence_timeout_ms <= olo_pkg::ABSENCE_RST;
            cfg_reg.power_down_ms      <= olo_pkg::FULL_OFF_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/olo_core.sv =====
`default_nettype none

module olo_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire olo_pkg::cfg_t   cfg,
    input  wire olo_pkg::poll_t  poll,
    output olo_pkg::result_t     res
);

    localparam int unsigned TW = olo_pkg::TimeW;

    logic          enabled_reg, enabled_next;
    logic          btn_stable_reg, btn_stable_next;
    logic          btn_last_reg, btn_last_next;
    logic [TW-1:0] btn_chg_time_reg, btn_chg_time_next;
    logic [TW-1:0] presence_time_reg, presence_time_next;
    logic          temp_off_reg, temp_off_next;
    logic [TW-1:0] temp_off_time_reg, temp_off_time_next;
    logic          full_off_reg, full_off_next;
    logic          saved_light_reg, saved_light_next;
    logic          saved_fan_reg, saved_fan_next;
    logic          paused_reg, paused_next;
    logic          motion_reg, motion_next;

    logic              lw, lo, fo;
    olo_pkg::disp_cmd_t disp;
    logic [TW-1:0]     deb_diff;
    logic [TW-1:0]     abs_diff;
    logic [TW-1:0]     off_diff;

    always_comb begin
        enabled_next       = enabled_reg;
        btn_stable_next    = btn_stable_reg;
        btn_last_next      = btn_last_reg;
        btn_chg_time_next  = btn_chg_time_reg;
        presence_time_next = presence_time_reg;
        temp_off_next      = temp_off_reg;
        temp_off_time_next = temp_off_time_reg;
        full_off_next      = full_off_reg;
        saved_light_next   = saved_light_reg;
        saved_fan_next     = saved_fan_reg;
        paused_next        = paused_reg;
        motion_next        = motion_reg;
        lw                 = 1'b0;
        lo                 = 1'b0;
        fo                 = 1'b0;
        disp               = olo_pkg::DISP_NONE;
        abs_diff           = '0;
        off_diff           = '0;

        // debounce the toggle button
        if (poll.button_level != btn_last_reg) begin
            btn_chg_time_next = poll.now_ms;
            btn_last_next     = poll.button_level;
        end
        deb_diff = poll.now_ms - btn_chg_time_next;
        if (deb_diff >= {{(TW-olo_pkg::DebounceW){1'b0}}, cfg.debounce_ms}
            && poll.button_level != btn_stable_reg) begin
            btn_stable_next = poll.button_level;
            if (!poll.button_level) begin
                enabled_next       = !enabled_reg;
                motion_next        = 1'b0;
                presence_time_next = poll.now_ms;
                temp_off_time_next = '0;
                temp_off_next      = 1'b0;
                if (enabled_reg) begin
                    full_off_next = 1'b0;
                    paused_next   = 1'b0;
                end else begin
                    paused_next = 1'b1;
                end
                disp = olo_pkg::DISP_WAKE;
            end
        end

        // presence logic
        if (!enabled_next) begin
            paused_next = 1'b0;
        end else begin
            if (poll.listening) begin
                presence_time_next = poll.now_ms;
                if (temp_off_next) begin
                    temp_off_next      = 1'b0;
                    temp_off_time_next = '0;
                    disp               = olo_pkg::DISP_WAKE;
                end
            end
            motion_next = poll.motion_level;
            if (poll.motion_level) begin
                presence_time_next = poll.now_ms;
                if (temp_off_next || full_off_next) begin
                    lw                 = 1'b1;
                    lo                 = saved_light_reg;
                    fo                 = saved_fan_reg;
                    disp               = olo_pkg::DISP_WAKE;
                    temp_off_next      = 1'b0;
                    temp_off_time_next = '0;
                    full_off_next      = 1'b0;
                end
                paused_next = 1'b0;
            end else if (!poll.listening) begin
                abs_diff = poll.now_ms - presence_time_next;
                if (!temp_off_next && !full_off_next
                    && abs_diff >= {{(TW-olo_pkg::DelayW){1'b0}},
                                    cfg.absence_timeout_ms}) begin
                    saved_light_next   = poll.light_now;
                    saved_fan_next     = poll.fan_now;
                    disp               = olo_pkg::DISP_SLEEP;
                    temp_off_time_next = poll.now_ms;
                    temp_off_next      = 1'b1;
                    paused_next        = 1'b1;
                end
                off_diff = poll.now_ms - temp_off_time_next;
                if (temp_off_next
                    && off_diff >= {{(TW-olo_pkg::DelayW){1'b0}},
                                    cfg.power_down_ms}) begin
                    lw                 = 1'b1;
                    lo                 = 1'b0;
                    fo                 = 1'b0;
                    temp_off_next      = 1'b0;
                    temp_off_time_next = '0;
                    disp               = olo_pkg::DISP_SLEEP;
                    full_off_next      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg       <= olo_pkg::START_EN_RST;
            btn_stable_reg    <= 1'b1;
            btn_last_reg      <= 1'b1;
            btn_chg_time_reg  <= '0;
            presence_time_reg <= '0;
            temp_off_reg      <= 1'b0;
            temp_off_time_reg <= '0;
            full_off_reg      <= 1'b0;
            saved_light_reg   <= 1'b0;
            saved_fan_reg     <= 1'b0;
            paused_reg        <= 1'b0;
            motion_reg        <= 1'b0;
        end else if (advance) begin
            enabled_reg       <= enabled_next;
            btn_stable_reg    <= btn_stable_next;
            btn_last_reg      <= btn_last_next;
            btn_chg_time_reg  <= btn_chg_time_next;
            presence_time_reg <= presence_time_next;
            temp_off_reg      <= temp_off_next;
            temp_off_time_reg <= temp_off_time_next;
            full_off_reg      <= full_off_next;
            saved_light_reg   <= saved_light_next;
            saved_fan_reg     <= saved_fan_next;
            paused_reg        <= paused_next;
            motion_reg        <= motion_next;
        end
    end

    assign res.loads_write      = lw;
    assign res.light_out        = lw & lo;
    assign res.fan_out          = lw & fo;
    assign res.display_cmd      = disp;
    assign res.engine_paused    = paused_next;
    assign res.presence_enabled = enabled_next;
    assign res.motion_seen      = motion_next;
    assign res.temp_off         = temp_off_next;
    assign res.full_off         = full_off_next;

endmodule

`default_nettype wire

// ===== hdl/occupancy_load_off_controller_top.sv =====
// An accepted poll is held in the input register; its result is registered as the core
// advances, held while m_ready stalls. Throughput: one poll per cycle while m_ready
// keeps up; the controller state updates in one pass between the input register and
// the result register. Reset (aresetn low, synchronous): registers return to defaults,
// presence control enabled, button released, all timers and off stages cleared.
`default_nettype none

module occupancy_load_off_controller_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic [olo_pkg::TimeW-1:0]     s_now_ms,
    input  wire logic                          s_button_level,
    input  wire logic                          s_motion_level,
    input  wire logic                          s_listening,
    input  wire logic                          s_light_now,
    input  wire logic                          s_fan_now,
    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      logic                          m_loads_write,
    output      logic                          m_light_out,
    output      logic                          m_fan_out,
    output      logic [1:0]                    m_display_cmd,
    output      logic                          m_engine_paused,
    output      logic                          m_presence_enabled,
    output      logic                          m_motion_seen,
    output      logic                          m_temp_off,
    output      logic                          m_full_off,
    input  wire logic                          cfg_we,
    input  wire logic [olo_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [olo_pkg::CfgDataW-1:0]  cfg_data
);

    olo_pkg::cfg_t    cfg;
    olo_pkg::poll_t   in_poll_reg;
    logic             in_valid_reg;
    olo_pkg::result_t out_res_reg;
    olo_pkg::result_t step_res;
    logic             out_valid_reg;
    logic             advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    olo_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    olo_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg),
        .poll    (in_poll_reg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_poll_reg.now_ms       <= s_now_ms;
            in_poll_reg.button_level <= s_button_level;
            in_poll_reg.motion_level <= s_motion_level;
            in_poll_reg.listening    <= s_listening;
            in_poll_reg.light_now    <= s_light_now;
            in_poll_reg.fan_now      <= s_fan_now;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_loads_write      = out_res_reg.loads_write;
    assign m_light_out        = out_res_reg.light_out;
    assign m_fan_out          = out_res_reg.fan_out;
    assign m_display_cmd      = out_res_reg.display_cmd;
    assign m_engine_paused    = out_res_reg.engine_paused;
    assign m_presence_enabled = out_res_reg.presence_enabled;
    assign m_motion_seen      = out_res_reg.motion_seen;
    assign m_temp_off         = out_res_reg.temp_off;
    assign m_full_off         = out_res_reg.full_off;

endmodule

`default_nettype wire

// ===== tb/occupancy_load_off_controller_checker.sv =====
`timescale 1ns / 1ps

module occupancy_load_off_controller_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [olo_pkg::TimeW-1:0]    s_now_ms,
    input  logic                         s_button_level,
    input  logic                         s_motion_level,
    input  logic                         s_listening,
    input  logic                         s_light_now,
    input  logic                         s_fan_now,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic                         m_loads_write,
    input  logic                         m_light_out,
    input  logic                         m_fan_out,
    input  logic [1:0]                   m_display_cmd,
    input  logic                         m_engine_paused,
    input  logic                         m_presence_enabled,
    input  logic                         m_motion_seen,
    input  logic                         m_temp_off,
    input  logic                         m_full_off,
    input  logic                         cfg_we,
    input  logic [olo_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [olo_pkg::CfgDataW-1:0] cfg_data,
    output int                           fail_count,
    output int                           pending_count
);

    logic [olo_pkg::DebounceW-1:0] debounce_ms;
    logic [olo_pkg::DelayW-1:0]    absence_ms;
    logic [olo_pkg::DelayW-1:0]    full_off_ms;

    logic                      ctl_enabled;
    logic                      btn_settled;
    logic                      btn_prev;
    logic [olo_pkg::TimeW-1:0] btn_edge_ms;
    logic [olo_pkg::TimeW-1:0] presence_ms;
    logic                      standby;
    logic [olo_pkg::TimeW-1:0] standby_ms;
    logic                      powered_down;
    logic                      keep_light;
    logic                      keep_fan;
    logic                      engine_hold;
    logic                      motion_mark;

    olo_pkg::result_t predicted_results[$];
    int unsigned      result_beats;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result beat %0d: %s got %0h, expected %0h",
                 $time, result_beats, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic toggle_presence(input logic en, input logic [olo_pkg::TimeW-1:0] now);
        ctl_enabled = en;
        motion_mark = 1'b0;
        presence_ms = now;
        standby_ms  = '0;
        standby     = 1'b0;
        if (!en) begin
            powered_down = 1'b0;
            engine_hold  = 1'b0;
        end else begin
            engine_hold = 1'b1;
        end
    endtask

    task automatic advance_off_timer(input olo_pkg::poll_t p, output olo_pkg::result_t r);
        logic [olo_pkg::TimeW-1:0] since;
        olo_pkg::disp_cmd_t        disp;
        logic                      lw;
        logic                      lo;
        logic                      fo;
        disp = olo_pkg::DISP_NONE;
        lw   = 1'b0;
        lo   = 1'b0;
        fo   = 1'b0;

        if (p.button_level != btn_prev) begin
            btn_edge_ms = p.now_ms;
            btn_prev    = p.button_level;
        end
        since = p.now_ms - btn_edge_ms;
        if (since >= 32'(debounce_ms) && p.button_level != btn_settled) begin
            btn_settled = p.button_level;
            if (!p.button_level) begin
                toggle_presence(!ctl_enabled, p.now_ms);
                disp = olo_pkg::DISP_WAKE;
            end
        end

        if (!ctl_enabled) begin
            engine_hold = 1'b0;
        end else begin
            if (p.listening) begin
                presence_ms = p.now_ms;
                if (standby) begin
                    standby    = 1'b0;
                    standby_ms = '0;
                    disp       = olo_pkg::DISP_WAKE;
                end
            end
            motion_mark = p.motion_level;
            if (p.motion_level) begin
                presence_ms = p.now_ms;
                if (standby || powered_down) begin
                    lw           = 1'b1;
                    lo           = keep_light;
                    fo           = keep_fan;
                    disp         = olo_pkg::DISP_WAKE;
                    standby      = 1'b0;
                    standby_ms   = '0;
                    powered_down = 1'b0;
                end
                engine_hold = 1'b0;
            end else if (!p.listening) begin
                since = p.now_ms - presence_ms;
                if (!standby && !powered_down && since >= 32'(absence_ms)) begin
                    keep_light  = p.light_now;
                    keep_fan    = p.fan_now;
                    disp        = olo_pkg::DISP_SLEEP;
                    standby_ms  = p.now_ms;
                    standby     = 1'b1;
                    engine_hold = 1'b1;
                end
                since = p.now_ms - standby_ms;
                if (standby && since >= 32'(full_off_ms)) begin
                    lw           = 1'b1;
                    lo           = 1'b0;
                    fo           = 1'b0;
                    standby      = 1'b0;
                    standby_ms   = '0;
                    disp         = olo_pkg::DISP_SLEEP;
                    powered_down = 1'b1;
                end
            end
        end

        r.loads_write      = lw;
        r.light_out        = lw & lo;
        r.fan_out          = lw & fo;
        r.display_cmd      = disp;
        r.engine_paused    = engine_hold;
        r.presence_enabled = ctl_enabled;
        r.motion_seen      = motion_mark;
        r.temp_off         = standby;
        r.full_off         = powered_down;
    endtask

    always @(posedge aclk) begin : watch
        olo_pkg::poll_t   p;
        olo_pkg::result_t want;
        if (!aresetn) begin
            debounce_ms  = olo_pkg::DEBOUNCE_RST;
            absence_ms   = olo_pkg::ABSENCE_RST;
            full_off_ms  = olo_pkg::FULL_OFF_RST;
            ctl_enabled  = olo_pkg::START_EN_RST;
            btn_settled  = 1'b1;
            btn_prev     = 1'b1;
            btn_edge_ms  = '0;
            presence_ms  = '0;
            standby      = 1'b0;
            standby_ms   = '0;
            powered_down = 1'b0;
            keep_light   = 1'b0;
            keep_fan     = 1'b0;
            engine_hold  = 1'b0;
            motion_mark  = 1'b0;
            predicted_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    olo_pkg::REG_DEBOUNCE: debounce_ms = cfg_data[olo_pkg::DebounceW-1:0];
                    olo_pkg::REG_ABSENCE:  absence_ms  = cfg_data[olo_pkg::DelayW-1:0];
                    olo_pkg::REG_FULL_OFF: full_off_ms = cfg_data[olo_pkg::DelayW-1:0];
                    olo_pkg::REG_START_EN: ;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                p.now_ms       = s_now_ms;
                p.button_level = s_button_level;
                p.motion_level = s_motion_level;
                p.listening    = s_listening;
                p.light_now    = s_light_now;
                p.fan_now      = s_fan_now;
                advance_off_timer(p, want);
                predicted_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("beat with nothing predicted, valid", 32'(m_valid),
                                    32'd0);
                end else begin
                    want = predicted_results.pop_front();
                    check_field("loads_write", 32'(m_loads_write), 32'(want.loads_write));
                    check_field("light_out", 32'(m_light_out), 32'(want.light_out));
                    check_field("fan_out", 32'(m_fan_out), 32'(want.fan_out));
                    check_field("display_cmd", 32'(m_display_cmd), 32'(want.display_cmd));
                    check_field("engine_paused", 32'(m_engine_paused),
                                32'(want.engine_paused));
                    check_field("presence_enabled", 32'(m_presence_enabled),
                                32'(want.presence_enabled));
                    check_field("motion_seen", 32'(m_motion_seen), 32'(want.motion_seen));
                    check_field("temp_off", 32'(m_temp_off), 32'(want.temp_off));
                    check_field("full_off", 32'(m_full_off), 32'(want.full_off));
                end
                result_beats++;
            end
        end
        pending_count = predicted_results.size();
    end

endmodule

// ===== tb/occupancy_load_off_controller_top_tb.sv =====
`timescale 1ns / 1ps

module occupancy_load_off_controller_top_tb;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned PhaseItems = 110;

    typedef enum {
        PH_SHORT,
        PH_ZERO,
        PH_LONG,
        PH_WILD
    } phase_kind_t;

    logic                         aclk           = 1'b0;
    logic                         aresetn        = 1'b0;
    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic [olo_pkg::TimeW-1:0]    s_now_ms       = '0;
    logic                         s_button_level = 1'b1;
    logic                         s_motion_level = 1'b0;
    logic                         s_listening    = 1'b0;
    logic                         s_light_now    = 1'b0;
    logic                         s_fan_now      = 1'b0;
    logic                         m_valid;
    logic                         m_ready        = 1'b0;
    logic                         m_loads_write;
    logic                         m_light_out;
    logic                         m_fan_out;
    logic [1:0]                   m_display_cmd;
    logic                         m_engine_paused;
    logic                         m_presence_enabled;
    logic                         m_motion_seen;
    logic                         m_temp_off;
    logic                         m_full_off;
    logic                         cfg_we         = 1'b0;
    logic [olo_pkg::CfgIdxW-1:0]  cfg_index      = '0;
    logic [olo_pkg::CfgDataW-1:0] cfg_data       = '0;

    int          fail_count;
    int          pending_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    logic [31:0] poll_clock_ms;
    logic        btn_hold;

    logic        pressure_req;
    logic        pressure_done;
    int unsigned hold_left;
    int unsigned rx_tick;
    logic [31:0] ready_mask;

    occupancy_load_off_controller_top i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_now_ms           (s_now_ms),
        .s_button_level     (s_button_level),
        .s_motion_level     (s_motion_level),
        .s_listening        (s_listening),
        .s_light_now        (s_light_now),
        .s_fan_now          (s_fan_now),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_loads_write      (m_loads_write),
        .m_light_out        (m_light_out),
        .m_fan_out          (m_fan_out),
        .m_display_cmd      (m_display_cmd),
        .m_engine_paused    (m_engine_paused),
        .m_presence_enabled (m_presence_enabled),
        .m_motion_seen      (m_motion_seen),
        .m_temp_off         (m_temp_off),
        .m_full_off         (m_full_off),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    occupancy_load_off_controller_checker i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_now_ms           (s_now_ms),
        .s_button_level     (s_button_level),
        .s_motion_level     (s_motion_level),
        .s_listening        (s_listening),
        .s_light_now        (s_light_now),
        .s_fan_now          (s_fan_now),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_loads_write      (m_loads_write),
        .m_light_out        (m_light_out),
        .m_fan_out          (m_fan_out),
        .m_display_cmd      (m_display_cmd),
        .m_engine_paused    (m_engine_paused),
        .m_presence_enabled (m_presence_enabled),
        .m_motion_seen      (m_motion_seen),
        .m_temp_off         (m_temp_off),
        .m_full_off         (m_full_off),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .pending_count      (pending_count)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: stall pattern redrawn whenever rx_tick[5:0] is zero, one long hold-off on request
    always @(negedge aclk) begin
        if (rx_tick[5:0] == 6'd0) begin
            case ($urandom_range(0, 3))
                0: ready_mask = '1;
                1: ready_mask = $urandom();
                2: ready_mask = $urandom() | $urandom();
                default: ready_mask = $urandom() & $urandom();
            endcase
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (pressure_req && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left = HoldCycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ready_mask[rx_tick[4:0]];
        end
        rx_tick = rx_tick + 1;
    end

    task automatic send_poll(input logic [31:0] now, input logic btn, input logic motion,
                             input logic listen, input logic light, input logic fan);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left = burst_left - 1;
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_now_ms       <= now;
        s_button_level <= btn;
        s_motion_level <= motion;
        s_listening    <= listen;
        s_light_now    <= light;
        s_fan_now      <= fan;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_count != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [olo_pkg::CfgIdxW-1:0] idx,
                             input logic [olo_pkg::CfgDataW-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input phase_kind_t kind, input logic stress);
        logic [31:0] max_step;
        int unsigned motion_odds;
        int unsigned listen_odds;
        logic        btn;
        drain_results();
        case (kind)
            PH_SHORT: begin
                write_reg(olo_pkg::REG_DEBOUNCE, 27'($urandom_range(0, 8)));
                write_reg(olo_pkg::REG_ABSENCE, 27'($urandom_range(1, 60)));
                write_reg(olo_pkg::REG_FULL_OFF, 27'($urandom_range(1, 60)));
                max_step = 10;
            end
            PH_ZERO: begin
                write_reg(olo_pkg::REG_DEBOUNCE, '0);
                write_reg(olo_pkg::REG_ABSENCE, 27'($urandom_range(0, 2)));
                write_reg(olo_pkg::REG_FULL_OFF, '0);
                max_step = 3;
            end
            PH_LONG: begin
                write_reg(olo_pkg::REG_DEBOUNCE,
                          $urandom_range(0, 1) ? 27'd1023 : 27'd1000);
                write_reg(olo_pkg::REG_ABSENCE,
                          $urandom_range(0, 1) ? 27'h7FF_FFFF : 27'd86400000);
                write_reg(olo_pkg::REG_FULL_OFF,
                          $urandom_range(0, 1) ? 27'h7FF_FFFF : 27'd86400000);
                max_step = 32'h0400_0000;
            end
            default: begin
                write_reg(olo_pkg::REG_DEBOUNCE, 27'($urandom()));
                write_reg(olo_pkg::REG_ABSENCE, 27'($urandom()));
                write_reg(olo_pkg::REG_FULL_OFF, 27'($urandom()));
                max_step = $urandom();
            end
        endcase
        write_reg(olo_pkg::REG_START_EN, 27'($urandom()));
        motion_odds = $urandom_range(4, 30);
        listen_odds = $urandom_range(6, 40);
        if (stress) begin
            pressure_req = 1'b1;
        end
        repeat (PhaseItems) begin
            poll_clock_ms = poll_clock_ms + $urandom_range(0, max_step);
            if ($urandom_range(0, 63) == 0) begin
                poll_clock_ms = $urandom();
            end
            if ($urandom_range(0, 7) == 0) begin
                btn_hold = ~btn_hold;
            end
            btn = btn_hold ^ ($urandom_range(0, 19) == 0);
            send_poll(poll_clock_ms, btn, $urandom_range(1, motion_odds) == 1,
                      $urandom_range(1, listen_odds) == 1, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        phase_kind_t kind;
        burst_left    = 0;
        btn_hold      = 1'b1;
        poll_clock_ms = '0;
        pressure_req  = 1'b0;
        pressure_done = 1'b0;
        hold_left     = 0;
        rx_tick       = 0;
        ready_mask    = '1;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default timers: sleep, listen wake, sleep, power down, motion restore
        send_poll(32'd0,       1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(32'd300000,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
        send_poll(32'd300001,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        send_poll(32'd600001,  1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
        send_poll(32'd1200001, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
        send_poll(32'd1200002, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        // press to disable, motion while disabled, press to enable, wrap
        send_poll(32'd1200010, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(32'd1200060, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(32'd1200100, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        send_poll(32'd1200200, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_poll(32'd1200300, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(32'd1200350, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
        send_poll(32'd0,       1'b1, 1'b0, 1'b0, 1'b0, 1'b0);

        // zero timers: both off stages in one poll, disable from power down
        drain_results();
        write_reg(olo_pkg::REG_DEBOUNCE, '0);
        write_reg(olo_pkg::REG_ABSENCE, '0);
        write_reg(olo_pkg::REG_FULL_OFF, '0);
        write_reg(olo_pkg::REG_START_EN, '0);
        send_poll(32'd5, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
        send_poll(32'd5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(32'd6, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(32'd7, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        send_poll(32'd8, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);

        // widest timers
        drain_results();
        write_reg(olo_pkg::REG_DEBOUNCE, 27'h3FF);
        write_reg(olo_pkg::REG_ABSENCE, 27'h7FF_FFFF);
        write_reg(olo_pkg::REG_FULL_OFF, 27'h7FF_FFFF);
        write_reg(olo_pkg::REG_START_EN, 27'h7FF_FFFF);
        send_poll(32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
        send_poll(32'h07FF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(32'h0800_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(32'h0800_03FF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);

        poll_clock_ms = $urandom();
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                1: kind = PH_LONG;
                2: kind = PH_ZERO;
                3: kind = PH_WILD;
                default: begin
                    case ($urandom_range(0, 9))
                        6: kind = PH_ZERO;
                        7, 8: kind = PH_LONG;
                        9: kind = PH_WILD;
                        default: kind = PH_SHORT;
                    endcase
                end
            endcase
            run_phase(kind, ph == 0);
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
